// ===== rtl/core/dpb_pkg.sv =====
// types and constants shared by the prd list builder
package dpb_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned BYTES_W    = 32;
  localparam int unsigned PLACED_W   = 33;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned SECTOR_W   = 17;
  localparam int unsigned CHUNK_W    = 17;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // results one block may give before the pass is cut as table full
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NRES_W      = 4;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd9;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd9;
  localparam logic [5:0]         LBA48_SECT_SHIFT = 6'd16;
  localparam logic [5:0]         LBA28_SECT_SHIFT = 6'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_SHIFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LBA48_MODE   = 1'b1;

  typedef enum logic [1:0] {
    CAUSE_DONE    = 2'd0,
    CAUSE_LIMIT   = 2'd1,
    CAUSE_FULL    = 2'd2,
    CAUSE_EXHAUST = 2'd3
  } cause_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FIT,
    ST_EMIT,
    ST_MARK
  } state_e;

  typedef struct packed {
    logic               first_block;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  block_address;
    logic [BYTES_W-1:0] block_bytes;
    logic               last_block;
  } in_item_t;

  typedef struct packed {
    logic                entry_valid;
    logic [ADDR_W-1:0]   entry_address;
    logic [COUNT_W-1:0]  entry_count;
    logic                end_of_run;
    logic [1:0]          stop_cause;
    logic [BYTES_W-1:0]  remaining_bytes;
    logic [SECTOR_W-1:0] sector_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic fit;
    logic emit;
    logic mark;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic zero_req;
    logic stopped;
    logic blk_zero;
    logic last;
    logic out_free;
    logic emit_end;
    logic blk_done;
  } status_t;

endpackage

// ===== rtl/core/dpb_if.sv =====
// valid/ready channel interfaces for blocks, entries and configuration
interface dpb_in_if import dpb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface dpb_out_if import dpb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface dpb_cfg_if import dpb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/dpb_ctrl.sv =====
// sequencer for block load, range setup and entry emission
module dpb_ctrl import dpb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.zero_req) begin
          state_d = ST_MARK;
        end else if (status_i.stopped) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.setup = 1'b1;
          state_d     = ST_FIT;
        end
      end
      ST_FIT: begin
        cmd_o.fit = 1'b1;
        if (status_i.blk_zero) begin
          state_d = status_i.last ? ST_MARK : ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_end || status_i.blk_done) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MARK: begin
        if (status_i.out_free) begin
          cmd_o.mark = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/dpb_datapath.sv =====
// pass counters, block cutter and result register
module dpb_datapath import dpb_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES   = 16,
  parameter int unsigned ENTRY_MAX_BYTES = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_item_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output out_item_t             out_item_o,
  input  cmd_t                  cmd_i,
  output status_t               status_o
);

  localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [BYTES_W-1:0] EMAX = BYTES_W'(ENTRY_MAX_BYTES);
  localparam logic [USED_W-1:0]  USED_LAST = USED_W'(TABLE_ENTRIES - 1);
  localparam logic [NRES_W-1:0]  NRES_LAST = NRES_W'(MAX_RESULTS - 1);

  logic [SHIFT_W-1:0]  shift_q;
  logic                lba_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [BYTES_W-1:0]  blk_q;
  logic                last_q;
  logic                zero_req_q;
  logic [BYTES_W-1:0]  left_q;
  logic [PLACED_W-1:0] placed_q;
  logic [USED_W-1:0]   used_q;
  logic                stopped_q;
  logic [PLACED_W-1:0] room_q;
  logic                over_q;
  logic [BYTES_W-1:0]  avail_q;
  logic [NRES_W-1:0]   nres_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [SHIFT_W-1:0]  eff_sh;
  logic [5:0]          lim_sh;
  logic [PLACED_W-1:0] limit;
  logic [PLACED_W:0]   room_diff;
  logic [CHUNK_W-1:0]  blk_cap, av_cap, chunk;
  logic [PLACED_W-1:0] placed_new;
  logic [BYTES_W-1:0]  left_new;
  logic                c_done, c_lim, c_full, blk_done, emit_end;
  logic [1:0]          emit_cause;
  logic                out_free;

  // clamp the sector size and form the per-command byte limit
  always_comb begin
    if (shift_q < SHIFT_MIN) begin
      eff_sh = SHIFT_MIN;
    end else if (shift_q > SHIFT_MAX) begin
      eff_sh = SHIFT_MAX;
    end else begin
      eff_sh = shift_q;
    end
  end
  assign lim_sh    = 6'(eff_sh) + (lba_q ? LBA48_SECT_SHIFT : LBA28_SECT_SHIFT);
  assign limit     = PLACED_W'(1) << lim_sh;
  assign room_diff = {1'b0, limit} - {1'b0, placed_q};

  // one entry: min of block, room left and entry size
  assign blk_cap = (blk_q >= EMAX) ? CHUNK_W'(EMAX) : blk_q[CHUNK_W-1:0];
  assign av_cap  = (avail_q >= EMAX) ? CHUNK_W'(EMAX) : avail_q[CHUNK_W-1:0];
  assign chunk   = (blk_cap < av_cap) ? blk_cap : av_cap;

  assign placed_new = placed_q + PLACED_W'(chunk);
  assign left_new   = left_q - BYTES_W'(chunk);
  assign c_done     = (left_q == BYTES_W'(chunk));
  assign c_lim      = over_q || (room_q == PLACED_W'(chunk));
  assign c_full     = (used_q == USED_LAST) || (nres_q == NRES_LAST);
  assign blk_done   = (blk_q == BYTES_W'(chunk));
  assign emit_end   = c_done || c_lim || c_full || (blk_done && last_q);

  always_comb begin
    if (c_done) begin
      emit_cause = CAUSE_DONE;
    end else if (c_lim) begin
      emit_cause = CAUSE_LIMIT;
    end else if (c_full) begin
      emit_cause = CAUSE_FULL;
    end else begin
      emit_cause = CAUSE_EXHAUST;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
      lba_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SECTOR_SHIFT: shift_q <= cfg_data_i;
        REG_LBA48_MODE:   lba_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      placed_q    <= '0;
      used_q      <= '0;
      stopped_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit || cmd_i.mark) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load && in_item_i.first_block) begin
        left_q    <= in_item_i.request_bytes;
        placed_q  <= '0;
        used_q    <= '0;
        stopped_q <= (in_item_i.request_bytes == '0);
      end
      if (cmd_i.emit) begin
        left_q      <= left_new;
        placed_q    <= placed_new;
        used_q      <= used_q + USED_W'(1);
        if (emit_end) begin
          stopped_q <= 1'b1;
        end
      end
      if (cmd_i.mark) begin
        stopped_q   <= 1'b1;
      end
    end
  end

  // block and range registers carry no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q     <= in_item_i.block_address;
      blk_q      <= in_item_i.block_bytes;
      last_q     <= in_item_i.last_block;
      zero_req_q <= in_item_i.first_block && (in_item_i.request_bytes == '0);
      nres_q     <= '0;
    end
    if (cmd_i.setup) begin
      over_q <= room_diff[PLACED_W];
      room_q <= room_diff[PLACED_W-1:0];
    end
    if (cmd_i.fit) begin
      if (over_q || (room_q >= {1'b0, left_q})) begin
        avail_q <= left_q;
      end else begin
        avail_q <= room_q[BYTES_W-1:0];
      end
    end
    if (cmd_i.emit) begin
      addr_q  <= addr_q + ADDR_W'(chunk);
      blk_q   <= blk_q - BYTES_W'(chunk);
      avail_q <= avail_q - BYTES_W'(chunk);
      room_q  <= room_q - PLACED_W'(chunk);
      nres_q  <= nres_q + NRES_W'(1);
      out_q.entry_valid   <= 1'b1;
      out_q.entry_address <= addr_q;
      out_q.entry_count   <= chunk[COUNT_W-1:0];
      if (emit_end) begin
        out_q.end_of_run      <= 1'b1;
        out_q.stop_cause      <= emit_cause;
        out_q.remaining_bytes <= left_new;
        out_q.sector_count    <= SECTOR_W'(placed_new >> eff_sh);
      end else begin
        out_q.end_of_run      <= 1'b0;
        out_q.stop_cause      <= CAUSE_DONE;
        out_q.remaining_bytes <= '0;
        out_q.sector_count    <= '0;
      end
    end
    if (cmd_i.mark) begin
      out_q.entry_valid     <= 1'b0;
      out_q.entry_address   <= '0;
      out_q.entry_count     <= '0;
      out_q.end_of_run      <= 1'b1;
      out_q.stop_cause      <= zero_req_q ? CAUSE_DONE : CAUSE_EXHAUST;
      out_q.remaining_bytes <= left_q;
      out_q.sector_count    <= SECTOR_W'(placed_q >> eff_sh);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.zero_req = zero_req_q;
  assign status_o.stopped  = stopped_q;
  assign status_o.blk_zero = (blk_q == '0);
  assign status_o.last     = last_q;
  assign status_o.out_free = out_free;
  assign status_o.emit_end = emit_end;
  assign status_o.blk_done = blk_done;

  a_no_emit_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !stopped_q)
    else $error("entry emitted while the pass is stopped");

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(TABLE_ENTRIES))
    else $error("prd table overfilled");

  a_marker_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.entry_valid |-> out_q.end_of_run)
    else $error("bare marker without end of run");

  a_end_stops_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && emit_end) || cmd_i.mark |=> stopped_q)
    else $error("pass not stopped after end of run");

  a_mid_run_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.end_of_run |->
      out_q.stop_cause == CAUSE_DONE && out_q.remaining_bytes == '0 &&
      out_q.sector_count == '0)
    else $error("end fields set on a mid-run entry");

endmodule

// ===== rtl/core/dma_prd_list_builder.sv =====
// top level of the bus-master prd list builder
// Turns a request, delivered as a stream of physical memory blocks, into
// bus-master PRD entries of at most ENTRY_MAX_BYTES each (a count of 0 means
// 65536). A block with first_block set opens a new pass and loads the request
// size; the pass stops when the request is covered, when the bytes placed
// reach the command limit (sector size times 256, or times 65536 in lba48
// mode), when TABLE_ENTRIES entries are used, after 16 entries from one block,
// or at the end of the last block. The final beat of a pass carries
// end_of_run with the cause, the uncovered bytes and the sectors covered;
// blocks after a stop give no beats until the next first block. A block is
// accepted, the limit subtracted and the range selected, then its entries are
// emitted; a block dropped after a stop goes from accept through the check
// state back to idle. Entries leave one per cycle, while the receiver takes
// them, from a single output register, and the next block is accepted while
// the last entry of the previous one still waits to be taken. Configuration
// writes are taken at any time and must only happen while the block is idle.
module dma_prd_list_builder import dpb_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES   = 16,
  parameter int unsigned ENTRY_MAX_BYTES = 65536
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dpb_cfg_if.sink  cfg_i,
  dpb_in_if.sink   in_i,
  dpb_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // configuration is a plain register write, always ready
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  dpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dpb_datapath #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .ENTRY_MAX_BYTES (ENTRY_MAX_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .in_item_i   (in_i.item),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.item),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== tb/sv/prd_entry_checker.sv =====
// checker that predicts the prd entries of the list builder and compares them beat by beat
module prd_entry_checker import dpb_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES   = 16,
  parameter int unsigned ENTRY_MAX_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpb_cfg_if          cfg,
  dpb_in_if           blk,
  dpb_out_if          prd,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned worked_blocks,
  output int unsigned entries_seen,
  output int unsigned ends_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SHOWN_FAILS = 10;

  logic [SHIFT_W-1:0]  cfg_shift;
  logic                cfg_lba48;
  logic [BYTES_W-1:0]  req_left;
  logic [PLACED_W-1:0] placed;
  int unsigned         used;
  logic                stopped;
  out_item_t           expected_entries[$];
  int unsigned         fails, worked, n_beats, n_ends;

  function automatic string beat_text(out_item_t b);
    return $sformatf("valid %0d addr %h count %h end %0d cause %0d remain %h sectors %h",
                     b.entry_valid, b.entry_address, b.entry_count, b.end_of_run,
                     b.stop_cause, b.remaining_bytes, b.sector_count);
  endfunction

  // cut one memory block into prd entries and queue them
  function automatic void build_entries(in_item_t it);
    out_item_t           run [MAX_RESULTS];
    logic [PLACED_W-1:0] limit, chunk, rest;
    logic [ADDR_W-1:0]   addr;
    logic [SHIFT_W-1:0]  sh;
    int unsigned         lim_shift;
    int                  n;
    logic                stop;
    cause_e              why;

    if (it.first_block || !stopped) worked++;
    if (it.first_block) begin
      req_left = it.request_bytes;
      placed   = '0;
      used     = 0;
      stopped  = 1'b0;
      if (req_left == '0) begin
        stopped               = 1'b1;
        run[0]                = '0;
        run[0].end_of_run     = 1'b1;
        run[0].stop_cause     = CAUSE_DONE;
        expected_entries.push_back(run[0]);
        return;
      end
    end
    if (stopped) return;

    // sector size clamps to the supported range
    if (cfg_shift < SHIFT_MIN) sh = SHIFT_MIN;
    else if (cfg_shift > SHIFT_MAX) sh = SHIFT_MAX;
    else sh = cfg_shift;
    lim_shift = 32'(sh) + 32'(cfg_lba48 ? LBA48_SECT_SHIFT : LBA28_SECT_SHIFT);
    limit     = PLACED_W'(1) << lim_shift;

    addr = it.block_address;
    rest = PLACED_W'(it.block_bytes);
    n    = 0;
    stop = 1'b0;
    why  = CAUSE_DONE;
    while (rest != '0 && !stop) begin
      chunk = rest;
      if (chunk > req_left) chunk = PLACED_W'(req_left);
      if (chunk > limit - placed) chunk = limit - placed;
      if (chunk > ENTRY_MAX_BYTES) chunk = PLACED_W'(ENTRY_MAX_BYTES);
      run[n]               = '0;
      run[n].entry_valid   = 1'b1;
      run[n].entry_address = addr;
      run[n].entry_count   = chunk[COUNT_W-1:0];
      n++;
      addr     = addr + chunk[ADDR_W-1:0];
      rest     = rest - chunk;
      req_left = req_left - chunk[BYTES_W-1:0];
      placed   = placed + chunk;
      used++;
      // precedence: request covered, then command limit, then table full
      if (req_left == '0) begin
        stop = 1'b1;
        why  = CAUSE_DONE;
      end else if (placed >= limit) begin
        stop = 1'b1;
        why  = CAUSE_LIMIT;
      end else if (used >= TABLE_ENTRIES || n >= MAX_RESULTS) begin
        stop = 1'b1;
        why  = CAUSE_FULL;
      end
    end

    if (!stop && it.last_block) begin
      stop = 1'b1;
      why  = CAUSE_EXHAUST;
      if (n == 0) begin
        run[0] = '0;
        n      = 1;
      end
    end

    if (stop) begin
      stopped                   = 1'b1;
      run[n-1].end_of_run       = 1'b1;
      run[n-1].stop_cause       = why;
      run[n-1].remaining_bytes  = req_left;
      run[n-1].sector_count     = SECTOR_W'(placed >> sh);
    end
    for (int i = 0; i < n; i++) expected_entries.push_back(run[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t got, want;
    logic      bad;
    if (!rst_ni) begin
      cfg_shift = SHIFT_RESET;
      cfg_lba48 = 1'b1;
      req_left  = '0;
      placed    = '0;
      used      = 0;
      stopped   = 1'b1;
      expected_entries.delete();
      fails     = 0;
      worked    = 0;
      n_beats   = 0;
      n_ends    = 0;
    end else begin
      // compare before queueing, a beat never answers the block of its own edge
      if (prd.valid && prd.ready) begin
        got = prd.item;
        n_beats++;
        if (got.end_of_run) n_ends++;
        if (expected_entries.size() == 0) begin
          fails++;
          if (fails <= SHOWN_FAILS) $display("%t unexpected beat: %s", $realtime, beat_text(got));
        end else begin
          want = expected_entries.pop_front();
          bad  = (got.entry_valid     !== want.entry_valid)   ||
                 (got.entry_address   !== want.entry_address) ||
                 (got.entry_count     !== want.entry_count)   ||
                 (got.end_of_run      !== want.end_of_run)    ||
                 (got.stop_cause      !== want.stop_cause)    ||
                 (got.remaining_bytes !== want.remaining_bytes) ||
                 (got.sector_count    !== want.sector_count);
          if (bad) begin
            fails++;
            if (fails <= SHOWN_FAILS) begin
              $display("%t mismatch, expected: %s", $realtime, beat_text(want));
              $display("%t mismatch, actual:   %s", $realtime, beat_text(got));
            end
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_SECTOR_SHIFT) cfg_shift = cfg.data[SHIFT_W-1:0];
        else if (cfg.index == REG_LBA48_MODE) cfg_lba48 = cfg.data[0];
      end
      if (blk.valid && blk.ready) build_entries(blk.item);
    end
    fail_count    <= fails;
    pending       <= expected_entries.size();
    worked_blocks <= worked;
    entries_seen  <= n_beats;
    ends_seen     <= n_ends;
  end

endmodule

// ===== tb/sv/tb_dma_prd_list_builder.sv =====
// testbench top for the prd list builder: stimulus, idling and verdict
module tb_dma_prd_list_builder import dpb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_ENTRIES   = 16;
  localparam int unsigned ENTRY_MAX_BYTES = 65536;
  // worst case is about 300 blocks of 16 beats each behind a slow receiver
  localparam int unsigned CYCLE_LIMIT     = 500000;
  // a block that gives no beat may still be in setup when the queue runs dry
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned PHASE_BLOCKS    = 24;
  localparam int unsigned N_SETTINGS      = 8;

  logic clk_i;
  logic rst_ni;

  dpb_cfg_if cfg_if ();
  dpb_in_if  blk_if ();
  dpb_out_if prd_if ();

  int unsigned fail_count, pending, worked_blocks, entries_seen, ends_seen;
  int unsigned cycles = 0;
  int unsigned blocks_sent;
  int unsigned settings_used;
  // percent of cycles in which the sender holds back or the receiver stalls
  int unsigned src_idle;
  int unsigned snk_idle;

  // register settings for the random phases: sector shift and lba48 mode,
  // out of range shifts and the limit/table tie among them
  logic [SHIFT_W-1:0] shift_plan [N_SETTINGS];
  logic               lba_plan   [N_SETTINGS];

  dma_prd_list_builder #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .ENTRY_MAX_BYTES(ENTRY_MAX_BYTES)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (blk_if),
    .out_o (prd_if)
  );

  prd_entry_checker #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .ENTRY_MAX_BYTES(ENTRY_MAX_BYTES)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg          (cfg_if),
    .blk          (blk_if),
    .prd          (prd_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .worked_blocks(worked_blocks),
    .entries_seen (entries_seen),
    .ends_seen    (ends_seen)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d beats outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: one ready decision per falling edge
  initial begin
    prd_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      prd_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // idling profile: 0 slow receiver, 1 slow sender, 2 no idling at all
  task automatic set_idling(int mode);
    case (mode)
      0: begin
        src_idle = 24;
        snk_idle = 71;
      end
      1: begin
        src_idle = 71;
        snk_idle = 24;
      end
      default: begin
        src_idle = 0;
        snk_idle = 0;
      end
    endcase
  endtask

  // drive one block beat and wait until it is taken; valid stays high so
  // back to back beats follow without a gap
  task automatic send_block(in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      blk_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    blk_if.valid <= 1'b1;
    blk_if.item  <= it;
    @(posedge clk_i);
    while (!blk_if.ready) @(posedge clk_i);
    blocks_sent++;
  endtask

  task automatic put_block(logic first, logic [31:0] req, logic [31:0] addr,
                           logic [31:0] nbytes, logic last);
    in_item_t it;
    it.first_block   = first;
    it.request_bytes = req;
    it.block_address = addr;
    it.block_bytes   = nbytes;
    it.last_block    = last;
    send_block(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // registers only change once every entry is out and the block has settled
  task automatic apply_setting(logic [SHIFT_W-1:0] shift, logic lba48);
    logic [CFG_DATA_W-1:0] mode_word;
    @(negedge clk_i);
    blk_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    // lba48 mode lives in bit 0, the upper bits are noise
    mode_word    = CFG_DATA_W'($urandom);
    mode_word[0] = lba48;
    write_reg(REG_SECTOR_SHIFT, CFG_DATA_W'(shift));
    write_reg(REG_LBA48_MODE, mode_word);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // one request: a first block and a few more, mostly well formed;
  // now and then the first flag is missing or the last flag is off
  task automatic send_request();
    int unsigned nblk, r;
    logic [31:0] req, nbytes;
    logic        first, last;
    r = $urandom_range(99);
    if (r < 4) req = 0;
    else if (r < 40) req = $urandom_range(8192, 1);
    else if (r < 75) req = $urandom_range(32'h10_0000, 8193);
    else if (r < 90) req = $urandom_range(32'h100_0000, 32'h10_0001);
    else req = $urandom;
    nblk = $urandom_range(6, 1);
    for (int k = 0; k < nblk; k++) begin
      r = $urandom_range(99);
      if (r < 6) nbytes = 0;
      else if (r < 45) nbytes = $urandom_range(32'h2000, 1);
      else if (r < 85) nbytes = $urandom_range(32'h4_0000, 32'h2001);
      else if (r < 95) nbytes = $urandom_range(32'h20_0000, 32'h4_0001);
      else nbytes = $urandom;
      first = (k == 0) && ($urandom_range(19) != 0);
      if (k == nblk - 1) last = ($urandom_range(9) != 0);
      else last = ($urandom_range(29) == 0);
      // request size is only read on a first block, elsewhere it is noise
      put_block(first, first ? req : $urandom, $urandom, nbytes, last);
    end
  endtask

  initial begin
    int unsigned mark;
    rst_ni        = 1'b0;
    blk_if.valid  = 1'b0;
    blk_if.item   = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    blocks_sent   = 0;
    settings_used = 0;
    src_idle      = 0;
    snk_idle      = 0;
    shift_plan = '{5'd9, 5'd16, 5'd0, 5'd31, 5'd12, 5'd16, 5'd10, 5'd11};
    lba_plan   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset setting: 512 byte sectors, lba48 limit
    set_idling(0);
    // block before any first block is dropped
    put_block(1'b0, 32'hFFFF_FFFF, 32'h0000_0040, 32'd100, 1'b1);
    // zero request gives a bare end marker
    put_block(1'b1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // full size entry encodes as count zero, request covered at once
    put_block(1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
    // block after a stop is dropped
    put_block(1'b0, 32'h0, 32'h1234_5678, 32'd50, 1'b0);
    // block split into three full entries and one byte
    put_block(1'b1, 32'hFFFF_FFFF, 32'h0000_1000, 32'h0003_0001, 1'b0);
    // empty block gives nothing, empty last block gives a bare marker
    put_block(1'b0, 32'h0, 32'h0, 32'h0, 1'b0);
    put_block(1'b0, 32'h0, 32'h0, 32'h0, 1'b1);
    // widest block: table fills after sixteen entries, addresses wrap
    put_block(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // last block used up before the request is covered
    put_block(1'b1, 32'd1000, 32'h8000_0000, 32'd300, 1'b1);
    // request covered on the last block: covered wins
    put_block(1'b1, 32'd100, 32'h0000_0200, 32'd100, 1'b1);
    // block longer than the request
    put_block(1'b1, 32'd70000, 32'h00AB_CDEF, 32'd200000, 1'b0);
    // table fills across four blocks
    put_block(1'b1, 32'h8000_0000, 32'h1000_0000, 32'h0005_0000, 1'b0);
    put_block(1'b0, 32'h0, 32'h2000_0000, 32'h0005_0000, 1'b0);
    put_block(1'b0, 32'h0, 32'h3000_0000, 32'h0005_0000, 1'b0);
    put_block(1'b0, 32'h0, 32'h4000_0000, 32'd10, 1'b1);

    // 256 sector limit with 512 byte sectors: 128 KiB per command
    apply_setting(5'd9, 1'b0);
    put_block(1'b1, 32'd200000, 32'h0100_0000, 32'd200000, 1'b0);
    // request exactly at the limit: covered wins over limit
    put_block(1'b1, 32'h0002_0000, 32'h0200_0000, 32'h0002_0000, 1'b1);
    // limit reached on the second block before its last flag counts
    put_block(1'b1, 32'h0010_0000, 32'h0300_0000, 32'h0001_0000, 1'b0);
    put_block(1'b0, 32'h0, 32'h0400_0000, 32'h0002_0000, 1'b1);

    // 4 KiB sectors: limit equals a full table, limit wins
    apply_setting(5'd12, 1'b0);
    put_block(1'b1, 32'hFFFF_FFFF, 32'h0500_0000, 32'h0010_0000, 1'b1);

    // random requests, one register setting per phase, idling in thirds
    for (int p = 0; p < N_SETTINGS; p++) begin
      set_idling(p < 2 ? 0 : (p < 5 ? 1 : 2));
      apply_setting(shift_plan[p], lba_plan[p]);
      mark = blocks_sent;
      while (blocks_sent - mark < PHASE_BLOCKS) send_request();
    end

    @(negedge clk_i);
    blk_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("sent %0d blocks (%0d acted on) under %0d register settings", blocks_sent,
             worked_blocks, settings_used + 1);
    $display("checked %0d prd beats and %0d pass ends, %0d failures", entries_seen, ends_seen,
             fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dpb_pkg.sv
rtl/core/dpb_if.sv
rtl/core/dpb_ctrl.sv
rtl/core/dpb_datapath.sv
rtl/core/dma_prd_list_builder.sv
tb/sv/prd_entry_checker.sv
tb/sv/tb_dma_prd_list_builder.sv
